/* design/pil_pkg.sv */
// Package with types, constants and codes shared by the positional list modules.
package pil_pkg;

  localparam int CAPACITY = 64;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 10;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int LEN_OUT_W = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic              cmd;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_bits;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0]    removed_bits;
    logic [1:0]           status;
    logic [LEN_OUT_W-1:0] length;
    logic                 is_empty;
  } out_t;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] data;
  } cell_ctrl_t;

endpackage

/* design/pil_cell.sv */
// One list cell that holds a word and shifts toward its neighbors on insert and remove.
module pil_cell (
  input  logic                      clk,
  input  pil_pkg::cell_ctrl_t       ctrl,
  input  logic [pil_pkg::POS_W-1:0] index,
  input  logic [pil_pkg::WORD_W-1:0] left_word,
  input  logic [pil_pkg::WORD_W-1:0] right_word,
  output logic [pil_pkg::WORD_W-1:0] word,
  output logic [pil_pkg::WORD_W-1:0] tap
);
  import pil_pkg::*;

  logic [WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    if (ctrl.ins) begin
      if (index > ctrl.pos) begin
        word_next = left_word;
      end else if (index == ctrl.pos) begin
        word_next = ctrl.data;
      end
    end else if (ctrl.rem) begin
      if (index >= ctrl.pos) begin
        word_next = right_word;
      end
    end
  end

  assign tap = (index == ctrl.pos) ? word : '0;

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

/* design/positional_insert_remove_list.sv */
// Top level of the positional insert/remove list built as a chain of word cells.
// A result is registered in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the output is drained; every cell shifts in parallel.
// A new transaction is accepted while the output register is empty or being drained.
// Reset (synchronous, active high) empties the list and the output register;
// the cell contents are left as they are and are never read before they are written.
module positional_insert_remove_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pil_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pil_pkg::out_t out_data
);
  import pil_pkg::*;

  logic [LEN_W-1:0]  fill;
  logic [LEN_W-1:0]  fill_next;
  logic [POS_W-1:0]  fill_wide;
  logic              accept;
  logic              is_insert;
  logic              list_full;
  logic              list_empty;
  cell_ctrl_t        ctrl;
  status_t           status_next;
  logic [WORD_W-1:0] removed_word;
  out_t              result;

  logic [WORD_W-1:0] words [CAPACITY];
  logic [WORD_W-1:0] taps  [CAPACITY];

  assign accept     = in_valid && in_ready;
  assign in_ready   = !out_valid || out_ready;
  assign is_insert  = (in_data.cmd == CMD_INSERT);
  assign fill_wide  = POS_W'(fill);
  assign list_full  = (fill == LEN_W'(CAPACITY));
  assign list_empty = (fill == '0);

  always_comb begin
    ctrl        = '0;
    ctrl.data   = in_data.data_bits;
    fill_next   = fill;
    status_next = ST_OK;
    if (is_insert) begin
      ctrl.pos = (in_data.position > fill_wide) ? fill_wide : in_data.position;
      if (list_full) begin
        status_next = ST_FULL;
      end else begin
        ctrl.ins  = accept;
        fill_next = fill + LEN_W'(1);
      end
    end else begin
      ctrl.pos = in_data.position;
      if (list_empty) begin
        status_next = ST_EMPTY;
      end else if (in_data.position >= fill_wide) begin
        status_next = ST_RANGE;
      end else begin
        ctrl.rem  = accept;
        fill_next = fill - LEN_W'(1);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;

    if (i == 0) begin : g_head
      assign left_word = '0;
    end else begin : g_body
      assign left_word = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_word = '0;
    end else begin : g_inner
      assign right_word = words[i+1];
    end

    pil_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .index      (POS_W'(i)),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i]),
      .tap        (taps[i])
    );
  end

  always_comb begin
    removed_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      removed_word = removed_word | taps[k];
    end
  end

  always_comb begin
    result.removed_bits = (status_next == ST_OK && !is_insert) ? removed_word : '0;
    result.status       = status_next;
    result.length       = LEN_OUT_W'(fill_next);
    result.is_empty     = (fill_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule
